@@ src/albs_pkg.sv @@
package albs_pkg;

  // Interpolation segments of the fractional log2 table.
  localparam int LOG_SEGMENTS = 64;
  localparam int SEG_W = $clog2(LOG_SEGMENTS + 1);

  // EWMA weights in Q16: old value and new sample.
  localparam logic [15:0] EWMA_OLD = 16'd53740;
  localparam logic [15:0] EWMA_NEW = 16'd11796;

  localparam logic [14:0] LUX_CLAMP_Q4 = 15'd32000;
  localparam logic [16:0] Q16_ONE = 17'd65536;
  localparam logic [8:0] DISPLAY_MAX = 9'd100;
  localparam logic [8:0] LED_MAX = 9'd255;
  localparam logic [8:0] DEAD_BAND = 9'd2;

  // Widths of the shared serial divider.
  localparam int DIV_NW = 36;
  localparam int DIV_DW = 20;
  localparam int DIV_QW = 18;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    REG_DISPLAY_STEP     = 4'd0,
    REG_LED_STEP         = 4'd1,
    REG_DISPLAY_FALLBACK = 4'd2,
    REG_LED_FALLBACK     = 4'd3,
    REG_DISPLAY_FLOOR    = 4'd4,
    REG_DISPLAY_SPAN     = 4'd5,
    REG_LED_FLOOR        = 4'd6,
    REG_LED_SPAN         = 4'd7
  } reg_index_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EWMA,
    ST_EWMA_END,
    ST_NORM,
    ST_TAB,
    ST_PREP,
    ST_DIV1_START,
    ST_DIV1,
    ST_DIV2_START,
    ST_DIV2,
    ST_MAP,
    ST_SLEW,
    ST_DONE
  } state_t;

  typedef logic [16:0] lut_t [0:LOG_SEGMENTS];

  // Shift-and-subtract division for the table and constant computations.
  function automatic longint unsigned const_div(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((num >> i) & 1);
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // Truncated log2 of m/65536 in Q16 by repeated squaring.
  function automatic longint unsigned frac_log2(input longint unsigned m);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = m;
    r = 0;
    if (m >= 131072) return 65536;
    if (m < 65536) return 0;
    b = 32768;
    for (int i = 0; i < 16; i++) begin
      v = (v * v) >> 16;
      if (v >= 131072) begin
        v = v >> 1;
        r = r | b;
      end
      b = b >> 1;
    end
    return r;
  endfunction

  function automatic longint unsigned bpoint(input longint unsigned k);
    return const_div(k * 65536, LOG_SEGMENTS);
  endfunction

  function automatic lut_t build_bk();
    lut_t tab;
    for (int k = 0; k <= LOG_SEGMENTS; k++) tab[k] = 17'(bpoint(k));
    return tab;
  endfunction

  function automatic lut_t build_lk();
    lut_t tab;
    for (int k = 0; k <= LOG_SEGMENTS; k++) tab[k] = 17'(frac_log2(65536 + bpoint(k)));
    return tab;
  endfunction

  // Full log2(y/4096) in Q16, used for the normalizing constant.
  function automatic longint unsigned log2_lux(input longint unsigned y);
    longint unsigned p, f, t, k, bk, bk1, lk, lk1, d, w, diff, interp;
    p = 23;
    while (p > 12 && ((y >> p) & 1) == 0) p = p - 1;
    f = (p >= 16) ? (y >> (p - 16)) : (y << (16 - p));
    t = (f - 65536) & 16'hFFFF;
    k = (t * LOG_SEGMENTS) >> 16;
    bk = bpoint(k);
    bk1 = bpoint(k + 1);
    lk = frac_log2(65536 + bk);
    lk1 = frac_log2(65536 + bk1);
    d = bk1 - bk;
    w = (t > bk) ? (t - bk) : 0;
    if (w > d) w = d;
    diff = (lk1 > lk) ? (lk1 - lk) : 0;
    interp = lk;
    if (d != 0) interp = lk + const_div(diff * w + (d >> 1), d);
    return (p - 12) * 65536 + interp;
  endfunction

  localparam lut_t BK_TAB = build_bk();
  localparam lut_t LK_TAB = build_lk();
  localparam logic [DIV_DW-1:0] LMAX = DIV_DW'(log2_lux(32000 * 256 + 4096));

endpackage

@@ src/albs_div.sv @@
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// DIV_QW bits, so the top dividend bits start out as the partial remainder.
// The divisor is captured at start and held for the whole division.
module albs_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [albs_pkg::DIV_NW-1:0]      dividend,
  input  logic [albs_pkg::DIV_DW-1:0]      divisor,
  output logic                             done,
  output logic [albs_pkg::DIV_QW-1:0]      quotient
);

  localparam int QW = albs_pkg::DIV_QW;
  localparam int DW = albs_pkg::DIV_DW;
  localparam int NW = albs_pkg::DIV_NW;

  logic [DW-1:0]        rem;
  logic [DW-1:0]        dvs;
  logic [QW-1:0]        low;
  logic [QW-1:0]        q;
  logic [$clog2(QW+1)-1:0] cnt;
  logic                 busy;
  logic [DW:0]          trial;
  logic                 fits;

  // Trial subtraction of one quotient bit.
  always_comb begin
    trial = {rem, low[QW-1]};
    fits  = trial >= {1'b0, dvs};
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ($clog2(QW+1))'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ($clog2(QW+1))'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DW'(dividend[NW-1:QW]);
      low <= dividend[QW-1:0];
      dvs <= divisor;
      q   <= '0;
    end else if (busy) begin
      rem <= fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      low <= {low[QW-2:0], 1'b0};
      q   <= {q[QW-2:0], fits};
    end
  end

  assign quotient = q;

endmodule

@@ src/ambient_light_brightness_slew.sv @@
// Ambient light to display and LED brightness. Each input transaction carries one
// sample in Q12.4 lux (tdata) and a valid flag (tuser) and yields one output
// transaction with the slewed display percent, LED level and a flag telling whether
// the sample updated the filter. An unused sample (invalid or negative) goes straight
// to the slew step. A valid sample passes through the bit-serial EWMA multiply (skipped
// for the first valid sample, which loads the filter), a leading-one shift and two
// divisions in one shared serial divider. A stalled output holds the block in its done
// state until the output register is free.
// One sample is processed at a time; a new one is taken while the previous result
// waits in the output register.
// Configuration writes are always accepted, and indexes beyond 7 are ignored.
module ambient_light_brightness_slew (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] lux_q4
  input  logic [0:0]  s_tuser,   // [0] lux_ok
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [6:0] display_percent, [14:7] led_level, [15] zero
  output logic [0:0]  m_tuser,   // [0] sample_used
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int SW = albs_pkg::SEG_W;

  albs_pkg::state_t state, state_next;

  logic [6:0]  display_step, display_fallback, display_floor, display_span;
  logic [7:0]  led_step, led_fallback, led_floor, led_span;

  logic [23:0] filtered;
  logic        loaded;
  logic [6:0]  display_now;
  logic [7:0]  led_now;
  logic        used;

  logic [22:0] sample_x;
  logic [41:0] acc;
  logic [3:0]  bit_cnt;
  logic [23:0] y;
  logic [3:0]  shift_cnt;
  logic [16:0] bk, bk1, lk, lk1;
  logic [15:0] t_frac;
  logic [16:0] d, w, diff;
  logic [19:0] lv;
  logic [16:0] n;
  logic [8:0]  tgt_disp, tgt_led;

  logic [6:0]  out_disp;
  logic [7:0]  out_led;
  logic        out_used;

  logic        div_start, div_done;
  logic [albs_pkg::DIV_NW-1:0] div_dividend;
  logic [albs_pkg::DIV_DW-1:0] div_divisor;
  logic [albs_pkg::DIV_QW-1:0] div_q;

  logic        in_take, in_used;
  logic [14:0] raw_clamped;
  logic [41:0] acc_step, acc_round;
  logic [26:0] k_prod;
  logic [SW-1:0] k_idx, k_idx1;
  logic [16:0] w_raw;
  logic [19:0] interp_sum;
  logic [24:0] disp_prod, led_prod;
  logic [8:0]  disp_map, led_map;
  logic [6:0]  disp_slew;
  logic [7:0]  led_slew;

  albs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Brightness step toward a target with a dead band.
  function automatic logic [8:0] approach(input logic [8:0] now, input logic [8:0] target,
                                          input logic [8:0] step);
    logic [8:0] gap;
    logic [9:0] up, dn;
    gap = (now > target) ? now - target : target - now;
    up  = {1'b0, now} + {1'b0, step};
    dn  = {1'b0, target} + {1'b0, step};
    if (gap <= albs_pkg::DEAD_BAND) return now;
    if (now < target) return (up < {1'b0, target}) ? up[8:0] : target;
    return ({1'b0, now} > dn) ? now - step : target;
  endfunction

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      display_step     <= 7'd8;
      led_step         <= 8'd6;
      display_fallback <= 7'd55;
      led_fallback     <= 8'd32;
      display_floor    <= 7'd18;
      display_span     <= 7'd82;
      led_floor        <= 8'd8;
      led_span         <= 8'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        albs_pkg::REG_DISPLAY_STEP:     display_step     <= cfg_data[6:0];
        albs_pkg::REG_LED_STEP:         led_step         <= cfg_data;
        albs_pkg::REG_DISPLAY_FALLBACK: display_fallback <= cfg_data[6:0];
        albs_pkg::REG_LED_FALLBACK:     led_fallback     <= cfg_data;
        albs_pkg::REG_DISPLAY_FLOOR:    display_floor    <= cfg_data[6:0];
        albs_pkg::REG_DISPLAY_SPAN:     display_span     <= cfg_data[6:0];
        albs_pkg::REG_LED_FLOOR:        led_floor        <= cfg_data;
        albs_pkg::REG_LED_SPAN:         led_span         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Combinational datapath pieces.
  always_comb begin
    in_take     = s_tvalid && s_tready;
    in_used     = s_tuser[0] && !s_tdata[15];
    raw_clamped = (s_tdata[14:0] > albs_pkg::LUX_CLAMP_Q4) ? albs_pkg::LUX_CLAMP_Q4
                                                           : s_tdata[14:0];
    acc_step    = {acc[40:0], 1'b0}
                + (albs_pkg::EWMA_OLD[bit_cnt] ? 42'(filtered) : 42'd0)
                + (albs_pkg::EWMA_NEW[bit_cnt] ? 42'(sample_x) : 42'd0);
    acc_round   = acc + 42'd32768;
    k_prod      = 27'(t_frac) * 27'(albs_pkg::LOG_SEGMENTS);
    k_idx       = SW'(k_prod[26:16]);
    k_idx1      = k_idx + 1'b1;
    w_raw       = ({1'b0, t_frac} > bk) ? {1'b0, t_frac} - bk : 17'd0;
    interp_sum  = 20'(lk) + 20'(div_q);
    disp_prod   = 25'(n) * 25'(display_span) + 25'd32768;
    led_prod    = 25'(n) * 25'(led_span) + 25'd32768;
    disp_map    = 9'(display_floor) + 9'(disp_prod[24:16]);
    led_map     = 9'(led_floor) + 9'(led_prod[24:16]);
    disp_slew   = 7'(approach(9'(display_now), tgt_disp, 9'(display_step)));
    led_slew    = 8'(approach(9'(led_now), tgt_led, 9'(led_step)));
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      albs_pkg::ST_IDLE: begin
        if (in_take) begin
          if (!in_used) state_next = albs_pkg::ST_SLEW;
          else if (loaded) state_next = albs_pkg::ST_EWMA;
          else state_next = albs_pkg::ST_NORM;
        end
      end
      albs_pkg::ST_EWMA:
        if (bit_cnt == 4'd0) state_next = albs_pkg::ST_EWMA_END;
      albs_pkg::ST_EWMA_END: state_next = albs_pkg::ST_NORM;
      albs_pkg::ST_NORM:
        if (y[23] || shift_cnt == 4'd11) state_next = albs_pkg::ST_TAB;
      albs_pkg::ST_TAB:        state_next = albs_pkg::ST_PREP;
      albs_pkg::ST_PREP:       state_next = albs_pkg::ST_DIV1_START;
      albs_pkg::ST_DIV1_START: state_next = albs_pkg::ST_DIV1;
      albs_pkg::ST_DIV1:
        if (div_done) state_next = albs_pkg::ST_DIV2_START;
      albs_pkg::ST_DIV2_START: state_next = albs_pkg::ST_DIV2;
      albs_pkg::ST_DIV2:
        if (div_done) state_next = albs_pkg::ST_MAP;
      albs_pkg::ST_MAP:        state_next = albs_pkg::ST_SLEW;
      albs_pkg::ST_SLEW:       state_next = albs_pkg::ST_DONE;
      albs_pkg::ST_DONE:
        if (!m_tvalid || m_tready) state_next = albs_pkg::ST_IDLE;
      default:                 state_next = albs_pkg::ST_IDLE;
    endcase
  end

  // State outputs: input handshake and divider operands.
  always_comb begin
    s_tready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = albs_pkg::LMAX;
    unique case (state)
      albs_pkg::ST_IDLE: s_tready = 1'b1;
      albs_pkg::ST_DIV1_START: begin
        div_start    = 1'b1;
        div_dividend = albs_pkg::DIV_NW'(diff) * albs_pkg::DIV_NW'(w)
                     + albs_pkg::DIV_NW'(d >> 1);
        div_divisor  = albs_pkg::DIV_DW'(d);
      end
      albs_pkg::ST_DIV2_START: begin
        div_start    = 1'b1;
        div_dividend = {lv, 16'd0} + albs_pkg::DIV_NW'(albs_pkg::LMAX >> 1);
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= albs_pkg::ST_IDLE;
      loaded      <= 1'b0;
      filtered    <= '0;
      display_now <= 7'd55;
      led_now     <= 8'd32;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == albs_pkg::ST_IDLE && in_take && in_used && !loaded) begin
        loaded   <= 1'b1;
        filtered <= {1'b0, raw_clamped, 8'd0};
      end
      if (state == albs_pkg::ST_EWMA_END) filtered <= acc_round[39:16];
      // A new result replaces a taken one in the same cycle.
      if (state == albs_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == albs_pkg::ST_SLEW) begin
        display_now <= disp_slew;
        led_now     <= led_slew;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      albs_pkg::ST_IDLE: begin
        used      <= in_used;
        sample_x  <= {raw_clamped, 8'd0};
        acc       <= '0;
        bit_cnt   <= 4'd15;
        shift_cnt <= 4'd0;
        y         <= {1'b0, raw_clamped, 8'd0} + 24'd4096;
        tgt_disp  <= (display_fallback > 7'd100) ? albs_pkg::DISPLAY_MAX
                                                 : 9'(display_fallback);
        tgt_led   <= 9'(led_fallback);
      end
      albs_pkg::ST_EWMA: begin
        acc     <= acc_step;
        bit_cnt <= bit_cnt - 1'b1;
      end
      albs_pkg::ST_EWMA_END: y <= acc_round[39:16] + 24'd4096;
      albs_pkg::ST_NORM: begin
        if (!(y[23] || shift_cnt == 4'd11)) begin
          y         <= {y[22:0], 1'b0};
          shift_cnt <= shift_cnt + 1'b1;
        end else begin
          t_frac <= y[22:7];
        end
      end
      albs_pkg::ST_TAB: begin
        bk  <= albs_pkg::BK_TAB[k_idx];
        bk1 <= albs_pkg::BK_TAB[k_idx1];
        lk  <= albs_pkg::LK_TAB[k_idx];
        lk1 <= albs_pkg::LK_TAB[k_idx1];
      end
      albs_pkg::ST_PREP: begin
        d    <= bk1 - bk;
        w    <= (w_raw > bk1 - bk) ? bk1 - bk : w_raw;
        diff <= (lk1 > lk) ? lk1 - lk : 17'd0;
      end
      albs_pkg::ST_DIV1:
        if (div_done) lv <= {4'd11 - shift_cnt, 16'd0} + interp_sum;
      albs_pkg::ST_DIV2:
        if (div_done) n <= (div_q > 18'(albs_pkg::Q16_ONE)) ? albs_pkg::Q16_ONE : div_q[16:0];
      albs_pkg::ST_MAP: begin
        tgt_disp <= (disp_map > albs_pkg::DISPLAY_MAX) ? albs_pkg::DISPLAY_MAX : disp_map;
        tgt_led  <= (led_map > albs_pkg::LED_MAX) ? albs_pkg::LED_MAX : led_map;
      end
      albs_pkg::ST_SLEW: begin
        out_disp <= disp_slew;
        out_led  <= led_slew;
        out_used <= used;
      end
      default: ;
    endcase
  end

  // Output register, loaded when the result is handed over.
  always_ff @(posedge clk) begin
    if (state == albs_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, out_led, out_disp};
      m_tuser <= out_used;
    end
  end

endmodule

@@ tb/sv/ambient_light_brightness_slew_checker.sv @@
`timescale 1ns / 100ps

module ambient_light_brightness_slew_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [6:0] display;
    logic [7:0] led;
    logic       used;
  } brightness_t;

  // Register shadows and filter state.
  logic [6:0] disp_step, disp_fb, disp_floor, disp_span;
  logic [7:0] led_step_r, led_fb, led_floor_r, led_span_r;
  logic [23:0] light_avg;
  logic        avg_loaded;
  logic [6:0]  disp_cur;
  logic [7:0]  led_cur;
  longint unsigned full_scale_log;

  brightness_t expected_q[$];

  // Truncated log2 of m/65536 in Q16.
  function automatic longint unsigned mant_log2(longint unsigned m);
    longint unsigned v, r, b;
    v = m;
    r = 0;
    b = 32768;
    if (m >= 131072) return 65536;
    if (m < 65536) return 0;
    for (int i = 0; i < 16; i++) begin
      v = (v * v) >> 16;
      if (v >= 131072) begin
        v = v >> 1;
        r = r | b;
      end
      b = b >> 1;
    end
    return r;
  endfunction

  function automatic longint unsigned seg_edge(longint unsigned k);
    return (k * 65536) / 64;
  endfunction

  // Piecewise-linear log2(y/4096) in Q16.
  function automatic longint unsigned lux_log(longint unsigned y);
    longint unsigned p, f, t, k, bk, bk1, lk, lk1, d, w, diff, v;
    p = 23;
    if (y < 4096) y = 4096;
    while (p > 12 && ((y >> p) & 1) == 0) p--;
    f = (p >= 16) ? (y >> (p - 16)) : (y << (16 - p));
    t = (f - 65536) & 16'hFFFF;
    k = (t * 64) >> 16;
    bk = seg_edge(k);
    bk1 = seg_edge(k + 1);
    lk = mant_log2(65536 + bk);
    lk1 = mant_log2(65536 + bk1);
    d = bk1 - bk;
    w = (t > bk) ? t - bk : 0;
    if (w > d) w = d;
    diff = (lk1 > lk) ? lk1 - lk : 0;
    v = lk;
    if (d != 0) v = lk + (diff * w + d / 2) / d;
    return (p - 12) * 65536 + v;
  endfunction

  function automatic int unsigned slew(int unsigned cur, int unsigned tgt, int unsigned st);
    int unsigned gap;
    gap = (cur > tgt) ? cur - tgt : tgt - cur;
    if (gap <= 2) return cur;
    if (cur < tgt) return (cur + st < tgt) ? cur + st : tgt;
    return (cur > tgt + st) ? cur - st : tgt;
  endfunction

  function automatic int unsigned level_for(longint unsigned n, int unsigned fl,
                                            int unsigned sp, int unsigned mx);
    int unsigned t;
    t = fl + int'((n * sp + 32768) >> 16);
    return (t > mx) ? mx : t;
  endfunction

  // Advance the predicted state by one sample and queue the result.
  task automatic predict_brightness(logic [15:0] raw, logic ok);
    longint unsigned x, n, lv;
    brightness_t r;
    int unsigned fb;
    if (!ok || raw[15]) begin
      fb = (disp_fb > 100) ? 100 : disp_fb;
      disp_cur = 7'(slew(disp_cur, fb, disp_step));
      led_cur = 8'(slew(led_cur, led_fb, led_step_r));
      r.used = 1'b0;
    end else begin
      x = ((raw > 32000) ? 32000 : raw) << 8;
      if (!avg_loaded) begin
        light_avg = 24'(x);
        avg_loaded = 1'b1;
      end else begin
        light_avg = 24'((longint'(light_avg) * 53740 + x * 11796 + 32768) >> 16);
      end
      lv = lux_log(longint'(light_avg) + 4096);
      n = (lv * 65536 + full_scale_log / 2) / full_scale_log;
      if (n > 65536) n = 65536;
      disp_cur = 7'(slew(disp_cur, level_for(n, disp_floor, disp_span, 100), disp_step));
      led_cur = 8'(slew(led_cur, level_for(n, led_floor_r, led_span_r, 255), led_step_r));
      r.used = 1'b1;
    end
    r.display = disp_cur;
    r.led = led_cur;
    expected_q.push_back(r);
  endtask

  initial full_scale_log = lux_log(32000 * 256 + 4096);

  assign pending = expected_q.size();

  always @(posedge clk) begin
    brightness_t got, want;
    if (rst) begin
      disp_step <= 7'd8;   led_step_r <= 8'd6;
      disp_fb <= 7'd55;    led_fb <= 8'd32;
      disp_floor <= 7'd18; disp_span <= 7'd82;
      led_floor_r <= 8'd8; led_span_r <= 8'd64;
      light_avg = '0;
      avg_loaded = 1'b0;
      disp_cur = 7'd55;
      led_cur = 8'd32;
      expected_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          albs_pkg::REG_DISPLAY_STEP:     disp_step <= cfg_data[6:0];
          albs_pkg::REG_LED_STEP:         led_step_r <= cfg_data;
          albs_pkg::REG_DISPLAY_FALLBACK: disp_fb <= cfg_data[6:0];
          albs_pkg::REG_LED_FALLBACK:     led_fb <= cfg_data;
          albs_pkg::REG_DISPLAY_FLOOR:    disp_floor <= cfg_data[6:0];
          albs_pkg::REG_DISPLAY_SPAN:     disp_span <= cfg_data[6:0];
          albs_pkg::REG_LED_FLOOR:        led_floor_r <= cfg_data;
          albs_pkg::REG_LED_SPAN:         led_span_r <= cfg_data;
          default: ;
        endcase
      end
      // Compare an output transaction with the oldest expectation.
      if (m_tvalid && m_tready) begin
        got.display = m_tdata[6:0];
        got.led = m_tdata[14:7];
        got.used = m_tuser[0];
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("Unexpected output transaction %h/%h", m_tdata, m_tuser);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want || m_tdata[15] !== 1'b0) begin
            if (errors < 10)
              $display("Mismatch: expected disp %0d led %0d used %0d, got disp %0d led %0d used %0d",
                       want.display, want.led, want.used, got.display, got.led, got.used);
            errors <= errors + 1;
          end
        end
      end
      // Configuration writes only happen while idle, so the new values apply here.
      if (s_tvalid && s_tready) predict_brightness(s_tdata, s_tuser[0]);
    end
  end

endmodule

@@ tb/sv/ambient_light_brightness_slew_tb.sv @@
`timescale 1ns / 100ps

module ambient_light_brightness_slew_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  int          errors;
  int          pending;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_cycles = 0;
  int          rx_wait = 0;
  int          rx_draw = 0;
  bit          rx_took = 0;
  bit          stim_done = 0;
  int          idle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ambient_light_brightness_slew DUT (.*);
  ambient_light_brightness_slew_checker u_checker (.*);

  // Send one sample after a random gap; valid stays up until the caller moves on.
  task automatic send_sample(logic [15:0] lux, logic ok, bit gaps);
    int g;
    g = gaps ? $urandom_range(14) : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= lux;
    s_tuser <= ok;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(albs_pkg::reg_index_t idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Wait until all results are back and the block has settled.
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic load_settings(int mode);
    logic [7:0] v[8];
    case (mode)
      0: v = '{8, 6, 55, 32, 18, 82, 8, 64};
      1: v = '{1, 1, 0, 0, 0, 0, 0, 0};
      2: v = '{100, 255, 100, 255, 100, 100, 255, 255};
      3: v = '{0, 0, 127, 200, 50, 50, 200, 100};
      default:
        v = '{$urandom_range(1, 100), $urandom_range(1, 255), $urandom_range(127),
              $urandom_range(255), $urandom_range(100), $urandom_range(100),
              $urandom_range(255), $urandom_range(255)};
    endcase
    for (int i = 0; i < 8; i++) write_reg(albs_pkg::reg_index_t'(i), v[i]);
    write_reg(albs_pkg::reg_index_t'(4'd9), 8'hFF);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_lux();
    case ($urandom_range(5))
      0: return 16'($urandom_range(64));
      1: return 16'($urandom_range(32000));
      2: return 16'($urandom_range(31000, 32767));
      3: return 16'($urandom);
      default: return 16'($urandom_range(4000));
    endcase
  endfunction

  // Note each output transaction for the receiver.
  always @(posedge clk) rx_took <= m_tvalid && m_tready;

  // Receiver: a drawn wait before each transaction, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= 400;
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_took) begin
      rx_draw = stim_done ? 0 : $urandom_range(14);
      m_tready <= (rx_draw == 0);
      rx_wait <= (rx_draw == 0) ? 0 : rx_draw - 1;
    end else if (rx_wait > 0) begin
      m_tready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted transaction.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count > 20000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] dir[$];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed samples at reset settings, including the first-load case.
    dir = '{16'd0, 16'd0, 16'd32000, 16'd32767, 16'd32001, 16'h8000, 16'hFFFF,
            16'd1, 16'd16, 16'd4096, 16'h5555, 16'h2AAA, 16'd32000, 16'd100};
    foreach (dir[i]) send_sample(dir[i], 1'b1, 1'b0);
    send_sample(16'd32000, 1'b0, 1'b0);
    send_sample(16'hFFFF, 1'b0, 1'b0);
    for (int i = 0; i < 5; i++) send_sample(16'd0, 1'b0, 1'b1);
    drain_outputs();

    // Long receiver hold-off while the sender keeps offering.
    hold_req = hold_req + 1;
    for (int i = 0; i < 10; i++) send_sample(rand_lux(), 1'b1, 1'b0);
    drain_outputs();

    // Random phases under several settings.
    for (int ph = 0; ph < 9; ph++) begin
      load_settings(ph == 0 ? 1 : ph == 1 ? 2 : ph == 2 ? 3 : ph == 8 ? 0 : 4);
      for (int i = 0; i < 150; i++)
        send_sample(rand_lux(), ($urandom_range(4) != 0), ($urandom_range(9) > 2));
      drain_outputs();
    end

    stim_done = 1;
    drain_outputs();
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
